[hdl/lsf_pkg.sv]
`default_nettype none

package lsf_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 12;

    localparam int SAMPLE_W = 24;
    localparam int COUNT_W  = 11;
    localparam int SUM_W    = 34;
    localparam int SQ_W     = 58;
    localparam int OUT_W    = 48;
    localparam int OUT_FRAC = 16;
    localparam int MUL_W    = 64;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QLVL_W   = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x_sample;
        logic signed [SAMPLE_W-1:0] y_sample;
        logic                       last_sample;
    } lsf_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] slope;
        logic signed [OUT_W-1:0] intercept;
        logic                    singular;
        logic                    saturated;
    } lsf_out_t;

    typedef struct packed {
        logic        [COUNT_W-1:0] count;
        logic signed [SUM_W-1:0]   sum_x;
        logic signed [SUM_W-1:0]   sum_y;
        logic signed [SQ_W-1:0]    sum_xx;
        logic signed [SQ_W-1:0]    sum_xy;
    } lsf_set_t;

endpackage

`default_nettype wire

[hdl/lsf_front.sv]
`default_nettype none

module lsf_front
    import lsf_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire lsf_in_t           sample,
    input  wire logic [QLVL_W-1:0] level,
    output logic                   busy,
    output logic                   push,
    output lsf_set_t               push_set
);

    localparam int SH = SAMPLE_W - SAMPLE_BITS;

    logic signed [SAMPLE_W-1:0]   x_tmp, y_tmp, x_ext, y_ext;
    logic signed [2*SAMPLE_W-1:0] xx_prod, xy_prod;
    logic                         accept;
    logic                         add;

    logic                         s1_valid_reg, s1_last_reg;
    logic signed [SAMPLE_W-1:0]   s1_x_reg, s1_y_reg;
    logic signed [2*SAMPLE_W-1:0] s1_xx_reg, s1_xy_reg;

    logic [COUNT_W-1:0]      count_reg, count_next;
    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic signed [SQ_W-1:0]  sum_xx_reg, sum_xx_next, sum_xy_reg, sum_xy_next;
    logic [QLVL_W:0]         pending;

    assign pending = {1'b0, level} + {{QLVL_W{1'b0}}, s1_valid_reg & s1_last_reg};
    assign busy    = (pending >= (QLVL_W+1)'(QDEPTH));
    assign accept  = start & ~busy;

    always_comb
    begin
        x_tmp   = sample.x_sample <<< SH;
        y_tmp   = sample.y_sample <<< SH;
        x_ext   = x_tmp >>> SH;
        y_ext   = y_tmp >>> SH;
        xx_prod = x_ext * x_ext;
        xy_prod = x_ext * y_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_last_reg  <= accept & sample.last_sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg  <= x_ext;
            s1_y_reg  <= y_ext;
            s1_xx_reg <= xx_prod;
            s1_xy_reg <= xy_prod;
        end
    end

    always_comb
    begin
        add         = s1_valid_reg && (count_reg < COUNT_W'(MAX_SAMPLES));
        count_next  = count_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        sum_xx_next = sum_xx_reg;
        sum_xy_next = sum_xy_reg;
        if (add)
        begin
            count_next  = count_reg + 1'b1;
            sum_x_next  = sum_x_reg + SUM_W'(s1_x_reg);
            sum_y_next  = sum_y_reg + SUM_W'(s1_y_reg);
            sum_xx_next = sum_xx_reg + SQ_W'(s1_xx_reg);
            sum_xy_next = sum_xy_reg + SQ_W'(s1_xy_reg);
        end
        push            = s1_last_reg;
        push_set.count  = count_next;
        push_set.sum_x  = sum_x_next;
        push_set.sum_y  = sum_y_next;
        push_set.sum_xx = sum_xx_next;
        push_set.sum_xy = sum_xy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_xy_reg <= '0;
        end
        else if (push)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xx_reg <= '0;
            sum_xy_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
            sum_xx_reg <= sum_xx_next;
            sum_xy_reg <= sum_xy_next;
        end
    end

endmodule

`default_nettype wire

[hdl/lsf_queue.sv]
`default_nettype none

module lsf_queue
    import lsf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire lsf_set_t          push_set,
    input  wire logic              pop,
    output lsf_set_t               head,
    output logic                   empty,
    output logic [QLVL_W-1:0]      level
);

    lsf_set_t            entries_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QLVL_W-1:0]   count_reg;

    assign head  = entries_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign level = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_set;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QLVL_W'(push) - QLVL_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != QLVL_W'(QDEPTH)) || pop)
        else $error("set queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("set queue underflow");

endmodule

`default_nettype wire

[hdl/lsf_back.sv]
`default_nettype none

module lsf_back
    import lsf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     empty,
    input  wire lsf_set_t head,
    output logic          pop,
    output logic          done,
    output lsf_out_t      result
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MUL_LOAD = 4'd1;
    localparam logic [3:0] ST_MUL_RUN  = 4'd2;
    localparam logic [3:0] ST_MUL_DONE = 4'd3;
    localparam logic [3:0] ST_DIV_LOAD = 4'd4;
    localparam logic [3:0] ST_DIV_RUN  = 4'd5;
    localparam logic [3:0] ST_DIV_DONE = 4'd6;

    localparam int MCNT_W = $clog2(MUL_W);
    localparam int DCNT_W = $clog2(PROD_W);

    logic [3:0]          state_reg, state_next;
    logic [2:0]          step_reg, step_next;
    logic                dstep_reg, dstep_next;
    logic [MCNT_W-1:0]   mcnt_reg, mcnt_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic                done_reg, done_next;
    logic                sat_reg, sat_next;

    lsf_set_t            set_reg;
    lsf_out_t            result_reg;
    logic [MUL_W-1:0]    ma_reg;
    logic [PROD_W-1:0]   mb_reg, acc_reg;
    logic                mneg_reg;
    logic signed [PROD_W-1:0] t_reg, den_reg, nm_reg, nc_reg;
    logic [PROD_W-1:0]   quot_reg, rem_reg, dvs_reg;
    logic                dneg_reg;

    logic signed [MUL_W-1:0]  op_a, op_b, n_ext;
    logic signed [PROD_W-1:0] prod, diff, num_sel, den_sel, an, ad;
    logic [PROD_W:0]          rem_sh;
    logic                     rem_ge;
    logic [PROD_W-1:0]        lim, qsat;
    logic                     over;
    logic signed [OUT_W-1:0]  qval;

    assign n_ext = $signed({{(MUL_W-COUNT_W){1'b0}}, set_reg.count});

    always_comb
    begin
        unique case (step_reg)
            3'd0:    begin op_a = n_ext;                op_b = MUL_W'(set_reg.sum_xx); end
            3'd1:    begin op_a = MUL_W'(set_reg.sum_x); op_b = MUL_W'(set_reg.sum_x); end
            3'd2:    begin op_a = n_ext;                op_b = MUL_W'(set_reg.sum_xy); end
            3'd3:    begin op_a = MUL_W'(set_reg.sum_x); op_b = MUL_W'(set_reg.sum_y); end
            3'd4:    begin op_a = MUL_W'(set_reg.sum_xx); op_b = MUL_W'(set_reg.sum_y); end
            default: begin op_a = MUL_W'(set_reg.sum_x); op_b = MUL_W'(set_reg.sum_xy); end
        endcase
    end

    always_comb
    begin
        prod    = mneg_reg ? -$signed(acc_reg) : $signed(acc_reg);
        diff    = t_reg - prod;
        num_sel = dstep_reg ? (nc_reg <<< OUT_FRAC) : (nm_reg <<< OUT_FRAC);
        den_sel = dstep_reg ? (den_reg <<< FRAC_BITS) : den_reg;
        an      = num_sel[PROD_W-1] ? -num_sel : num_sel;
        ad      = den_sel[PROD_W-1] ? -den_sel : den_sel;
        rem_sh  = {rem_reg, quot_reg[PROD_W-1]};
        rem_ge  = (rem_sh >= {1'b0, dvs_reg});
        lim     = dneg_reg ? (PROD_W'(1) << (OUT_W-1)) : ((PROD_W'(1) << (OUT_W-1)) - 1'b1);
        over    = (quot_reg > lim);
        qsat    = over ? lim : quot_reg;
        qval    = dneg_reg ? -$signed(qsat[OUT_W-1:0]) : $signed(qsat[OUT_W-1:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        dstep_next = dstep_reg;
        mcnt_next  = mcnt_reg;
        dcnt_next  = dcnt_reg;
        sat_next   = sat_reg;
        done_next  = 1'b0;
        pop        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    step_next  = 3'd0;
                    sat_next   = 1'b0;
                    state_next = ST_MUL_LOAD;
                end
            end
            ST_MUL_LOAD:
            begin
                mcnt_next  = '0;
                state_next = ST_MUL_RUN;
            end
            ST_MUL_RUN:
            begin
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == MCNT_W'(MUL_W-1))
                begin
                    state_next = ST_MUL_DONE;
                end
            end
            ST_MUL_DONE:
            begin
                if (step_reg == 3'd1 && diff == '0)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (step_reg == 3'd5)
                begin
                    dstep_next = 1'b0;
                    state_next = ST_DIV_LOAD;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_MUL_LOAD;
                end
            end
            ST_DIV_LOAD:
            begin
                dcnt_next  = '0;
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(PROD_W-1))
                begin
                    state_next = ST_DIV_DONE;
                end
            end
            ST_DIV_DONE:
            begin
                sat_next = sat_reg | over;
                if (dstep_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    dstep_next = 1'b1;
                    state_next = ST_DIV_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            dstep_reg <= 1'b0;
            mcnt_reg  <= '0;
            dcnt_reg  <= '0;
            sat_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            dstep_reg <= dstep_next;
            mcnt_reg  <= mcnt_next;
            dcnt_reg  <= dcnt_next;
            sat_reg   <= sat_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            set_reg <= head;
        end
        unique case (state_reg)
            ST_MUL_LOAD:
            begin
                ma_reg   <= op_a[MUL_W-1] ? -op_a : op_a;
                mb_reg   <= PROD_W'(op_b[MUL_W-1] ? -op_b : op_b);
                mneg_reg <= op_a[MUL_W-1] ^ op_b[MUL_W-1];
                acc_reg  <= '0;
            end
            ST_MUL_RUN:
            begin
                if (ma_reg[0])
                begin
                    acc_reg <= acc_reg + mb_reg;
                end
                ma_reg <= ma_reg >> 1;
                mb_reg <= mb_reg << 1;
            end
            ST_MUL_DONE:
            begin
                if (!step_reg[0])
                begin
                    t_reg <= prod;
                end
                else if (step_reg == 3'd1)
                begin
                    den_reg <= diff;
                    if (diff == '0)
                    begin
                        result_reg.slope     <= '0;
                        result_reg.intercept <= '0;
                        result_reg.singular  <= 1'b1;
                        result_reg.saturated <= 1'b0;
                    end
                end
                else if (step_reg == 3'd3)
                begin
                    nm_reg <= diff;
                end
                else
                begin
                    nc_reg <= diff;
                end
            end
            ST_DIV_LOAD:
            begin
                quot_reg <= (an << 1) + ad;
                dvs_reg  <= ad << 1;
                rem_reg  <= '0;
                dneg_reg <= num_sel[PROD_W-1] ^ den_sel[PROD_W-1];
            end
            ST_DIV_RUN:
            begin
                rem_reg  <= rem_ge ? PROD_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[PROD_W-1:0];
                quot_reg <= {quot_reg[PROD_W-2:0], rem_ge};
            end
            ST_DIV_DONE:
            begin
                if (dstep_reg)
                begin
                    result_reg.intercept <= qval;
                    result_reg.singular  <= 1'b0;
                    result_reg.saturated <= sat_reg | over;
                end
                else
                begin
                    result_reg.slope <= qval;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.singular) |-> (result.slope == '0) && (result.intercept == '0)
            && !result.saturated)
        else $error("singular fit with nonzero fields");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_MUL_LOAD))
        else $error("set taken outside idle");

endmodule

`default_nettype wire

[hdl/least_squares_line_fit.sv]
// channel   signals                         transfer
// sample    start, busy, sample (lsf_in_t)  start high and busy low at a rising edge
// result    done, result (lsf_out_t)        done high for one cycle, always taken
//
// samples are taken one per cycle while busy is low; sums update the next cycle
// a fit runs in the solver: six 64-bit serial multiplies and two 128-bit serial
// divides per set; a singular set ends after the second multiply
// finished sets wait in a two-entry queue; busy rises only while that queue
// and a last sample still in flight fill it, so accumulation runs on during a fit
// reset clears the sums, the queue and the solver; no clearing pass

`default_nettype none

module least_squares_line_fit
    import lsf_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire lsf_in_t sample,
    output logic         busy,
    output logic         done,
    output lsf_out_t     result
);

    logic              push, pop, empty;
    lsf_set_t          push_set, head;
    logic [QLVL_W-1:0] level;

    lsf_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .sample   (sample),
        .level    (level),
        .busy     (busy),
        .push     (push),
        .push_set (push_set)
    );

    lsf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_set (push_set),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .level    (level)
    );

    lsf_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .head   (head),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire
